// ----- sv/matrix_inverse_lu_4x4_top_macros.svh -----
// assertion macros shared by the checker
`ifndef MATRIX_INVERSE_LU_4X4_TOP_MACROS_SVH
`define MATRIX_INVERSE_LU_4X4_TOP_MACROS_SVH
// property checked on each rising edge, off while reset is low
`define MIL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: check failed");
// a stalled word stays valid and unchanged until taken
`define MIL_ASSERT_HOLD(label, clk, rst_n, vld, rdy, data) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(data))) else $error("%m: stalled word not held");
`endif

// ----- sv/mil_pkg.sv -----
package mil_pkg;
  localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

  typedef enum logic [3:0] {
    ST_LOAD, ST_PIV, ST_FDIV, ST_FWAIT, ST_UPD, ST_FIN, ST_SINIT, ST_FWD,
    ST_BACK, ST_BDIV, ST_BWAIT, ST_NEXT, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_SING = 2'd1,
    STAT_SAT  = 2'd2
  } status_e;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_sts_t;

  function automatic logic [47:0] sat_add(input logic signed [48:0] s, output logic o);
    o = 1'b0;
    if (s > 49'(MAX48)) begin
      o = 1'b1;
      return MAX48;
    end
    if (s < 49'sh1_8000_0000_0000) begin
      o = 1'b1;
      return MIN48;
    end
    return s[47:0];
  endfunction
endpackage

// ----- sv/matrix_inverse_lu_4x4_top.sv -----
// 4x4 fixed-point matrix inverter, Doolittle lu without pivoting
// s_axis: one word per matrix element, row-major, signed q16.16
// m_axis: 16 inverse words in row-major order, tlast on the sixteenth
// one shared serial divider (one quotient per start, flagged by done)
// and one multiplier taking half of a per cycle
// are run by a sequencer
// the sixteenth item starts the solve: 22 divisions and 62 products,
// then 16 output words
// a zero pivot gives the identity with status 1; otherwise any saturation gives
// status 2 on every word of that matrix
// s_axis_tready is low while factoring, solving or emitting
// m_axis_tvalid holds its word until taken; a stall holds the sequencer
// reset clears load count and sequencer; matrix stores are not cleared
module matrix_inverse_lu_4x4_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // matrix_element[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // inverse_element[31:0], element_index[35:32], pad
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser   // status
);
  logic signed [47:0] wm_q [16];
  logic signed [47:0] wm_d [16];
  logic signed [47:0] sv_q [4];
  logic signed [47:0] sv_d [4];
  logic signed [47:0] inv_q [16];
  logic signed [47:0] inv_d [16];
  mil_pkg::state_e st_q, st_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] k_q, k_d, i_q, i_d, j_q, j_d, c_q, c_d;
  logic [1:0] ph_q, ph_d;
  logic signed [47:0] acc_q, acc_d;
  logic ovf_q, ovf_d, sing_q, sing_d, ovalid_q, ovalid_d;
  logic [1:0] stat_q, stat_d;
  logic signed [47:0] ma, mb, dn, dd, mp, dq;
  logic movf;
  logic mhi;
  mil_pkg::div_ctl_t dctl;
  mil_pkg::div_sts_t dsts;

  assign mhi = (ph_q == 2'd1);

  mil_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i(clk_i), .hi_i(mhi), .a_i(ma), .b_i(mb), .p_o(mp), .ovf_o(movf)
  );
  mil_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(dctl), .num_i(dn), .den_i(dd),
    .sts_o(dsts), .quo_o(dq)
  );

  assign s_axis_tready = (st_q == mil_pkg::ST_LOAD);

  always_comb begin
    logic o;
    logic signed [47:0] s;
    st_d = st_q; cnt_d = cnt_q; k_d = k_q; i_d = i_q; j_d = j_q; c_d = c_q;
    ph_d = ph_q; acc_d = acc_q; ovf_d = ovf_q; sing_d = sing_q; stat_d = stat_q;
    ovalid_d = ovalid_q;
    wm_d = wm_q; sv_d = sv_q; inv_d = inv_q;
    dctl.start = 1'b0;
    ma = wm_q[{i_q, c_q}]; mb = wm_q[{k_q, c_q}];
    dn = wm_q[{i_q, k_q}]; dd = wm_q[{k_q, k_q}];
    o = 1'b0; s = '0;
    case (st_q)
      mil_pkg::ST_LOAD: begin
        if (s_axis_tvalid) begin
          wm_d[cnt_q] = 48'(signed'(s_axis_tdata));
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == 4'd15) begin
            k_d = '0; ovf_d = 1'b0; sing_d = 1'b0;
            st_d = mil_pkg::ST_PIV;
          end
        end
      end
      mil_pkg::ST_PIV: begin
        if (wm_q[{k_q, k_q}] == '0) begin
          sing_d = 1'b1; st_d = mil_pkg::ST_FIN;
        end else begin
          i_d = k_q + 1'b1; st_d = mil_pkg::ST_FDIV;
        end
      end
      mil_pkg::ST_FDIV: begin
        dctl.start = 1'b1; st_d = mil_pkg::ST_FWAIT;
      end
      mil_pkg::ST_FWAIT: begin
        if (dsts.done) begin
          wm_d[{i_q, k_q}] = dq;
          ovf_d = ovf_q | dsts.ovf;
          c_d = k_q + 1'b1; ph_d = '0; st_d = mil_pkg::ST_UPD;
        end
      end
      mil_pkg::ST_UPD: begin
        // a = factor, b = u row element, product taken in phase 2
        ma = wm_q[{i_q, k_q}]; mb = wm_q[{k_q, c_q}];
        ph_d = ph_q + 1'b1;
        if (ph_q == 2'd2) begin
          s = mil_pkg::sat_add(49'(wm_q[{i_q, c_q}]) - 49'(mp), o);
          wm_d[{i_q, c_q}] = s;
          ovf_d = ovf_q | o | movf;
          ph_d = '0;
          if (c_q == 2'd3) begin
            if (i_q == 2'd3) begin
              if (k_q == 2'd2) st_d = mil_pkg::ST_FIN;
              else begin
                k_d = k_q + 1'b1; st_d = mil_pkg::ST_PIV;
              end
            end else begin
              i_d = i_q + 1'b1; st_d = mil_pkg::ST_FDIV;
            end
          end else c_d = c_q + 1'b1;
        end
      end
      mil_pkg::ST_FIN: begin
        if (!sing_q && wm_q[15] == '0) sing_d = 1'b1;
        j_d = '0;
        st_d = (sing_q || wm_q[15] == '0) ? mil_pkg::ST_OUT : mil_pkg::ST_SINIT;
        cnt_d = '0; ovalid_d = sing_q || wm_q[15] == '0;
        stat_d = mil_pkg::STAT_SING;
      end
      mil_pkg::ST_SINIT: begin
        for (int n = 0; n < 4; n++)
          sv_d[n] = (2'(n) == j_q) ? 48'(1) << FRAC_BITS : '0;
        i_d = 2'd1; c_d = '0; ph_d = '0; acc_d = sv_d[1];
        st_d = mil_pkg::ST_FWD;
      end
      mil_pkg::ST_FWD: begin
        ma = wm_q[{i_q, c_q}]; mb = sv_q[c_q];
        ph_d = ph_q + 1'b1;
        if (ph_q == 2'd2) begin
          s = mil_pkg::sat_add(49'(acc_q) - 49'(mp), o);
          ovf_d = ovf_q | o | movf;
          ph_d = '0;
          if (c_q + 1'b1 == i_q) begin
            sv_d[i_q] = s;
            if (i_q == 2'd3) begin
              i_d = 2'd3; c_d = '0; acc_d = '0; st_d = mil_pkg::ST_BDIV;
            end else begin
              i_d = i_q + 1'b1; c_d = '0; acc_d = sv_q[i_q + 1'b1];
            end
          end else begin
            acc_d = s; c_d = c_q + 1'b1;
          end
        end
      end
      mil_pkg::ST_BACK: begin
        // acc accumulates u[i][c]*inv[c][j] for c>i
        ma = wm_q[{i_q, c_q}]; mb = inv_q[{c_q, j_q}];
        ph_d = ph_q + 1'b1;
        if (ph_q == 2'd2) begin
          s = mil_pkg::sat_add(49'(acc_q) + 49'(mp), o);
          ovf_d = ovf_q | o | movf;
          acc_d = s; ph_d = '0;
          if (c_q == 2'd3) st_d = mil_pkg::ST_BDIV;
          else c_d = c_q + 1'b1;
        end
      end
      mil_pkg::ST_BDIV: begin
        s = mil_pkg::sat_add(49'(sv_q[i_q]) - 49'(acc_q), o);
        ovf_d = ovf_q | o;
        dn = s; dd = wm_q[{i_q, i_q}];
        dctl.start = 1'b1; st_d = mil_pkg::ST_BWAIT;
      end
      mil_pkg::ST_BWAIT: begin
        if (dsts.done) begin
          inv_d[{i_q, j_q}] = dq;
          ovf_d = ovf_q | dsts.ovf;
          if (i_q == 2'd0) st_d = mil_pkg::ST_NEXT;
          else begin
            i_d = i_q - 1'b1; c_d = i_q; acc_d = '0; ph_d = '0;
            st_d = mil_pkg::ST_BACK;
          end
        end
      end
      mil_pkg::ST_NEXT: begin
        if (j_q == 2'd3) begin
          for (int n = 0; n < 16; n++)
            if (inv_q[n] > 48'sh0000_7FFF_FFFF || inv_q[n] < 48'shFFFF_8000_0000)
              ovf_d = 1'b1;
          st_d = mil_pkg::ST_OUT; cnt_d = '0; ovalid_d = 1'b1;
          stat_d = ovf_d ? mil_pkg::STAT_SAT : mil_pkg::STAT_OK;
        end else begin
          j_d = j_q + 1'b1; st_d = mil_pkg::ST_SINIT;
        end
      end
      mil_pkg::ST_OUT: begin
        if (m_axis_tready) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == 4'd15) begin
            ovalid_d = 1'b0; st_d = mil_pkg::ST_LOAD;
          end
        end
      end
      default: st_d = mil_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= mil_pkg::ST_LOAD;
      cnt_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wm_q <= wm_d; sv_q <= sv_d; inv_q <= inv_d;
    k_q <= k_d; i_q <= i_d; j_q <= j_d; c_q <= c_d; ph_q <= ph_d;
    acc_q <= acc_d; ovf_q <= ovf_d; sing_q <= sing_d; stat_q <= stat_d;
  end

  logic signed [47:0] ov;
  logic [31:0] oe;
  always_comb begin
    ov = inv_q[cnt_q];
    if (stat_q == mil_pkg::STAT_SING)
      oe = (cnt_q[3:2] == cnt_q[1:0]) ? 32'(48'(1) << FRAC_BITS) : '0;
    else if (ov > 48'sh0000_7FFF_FFFF) oe = 32'h7FFF_FFFF;
    else if (ov < 48'shFFFF_8000_0000) oe = 32'h8000_0000;
    else oe = ov[31:0];
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {4'd0, cnt_q, oe};
  assign m_axis_tlast = (cnt_q == 4'd15);
  assign m_axis_tuser = stat_q;
endmodule

// ----- sv/mil_div.sv -----
module mil_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mil_pkg::div_ctl_t  ctl_i,
  input  logic signed [47:0] num_i,
  input  logic signed [47:0] den_i,
  output mil_pkg::div_sts_t  sts_o,
  output logic signed [47:0] quo_o
);
  localparam int unsigned NB = 48 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NB + 1);

  logic [NB-1:0] num_q, num_d;
  logic [48:0] rem_q, rem_d;
  logic [47:0] den_q, den_d;
  logic [48:0] quo_q, quo_d;
  logic big_q, big_d, neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [48:0] rs, lim;
  logic [47:0] un, ud;
  logic qb;
  logic [48:0] qn;

  assign lim = neg_q ? 49'h0_8000_0000_0000 : 49'h0_7FFF_FFFF_FFFF;

  always_comb begin
    un = num_i[47] ? 48'(-num_i) : num_i;
    ud = den_i[47] ? 48'(-den_i) : den_i;
    num_d = num_q; rem_d = rem_q; den_d = den_q; quo_d = quo_q; big_d = big_q;
    neg_d = neg_q; busy_d = busy_q; done_d = 1'b0; cnt_d = cnt_q;
    rs = {rem_q[47:0], num_q[NB-1]};
    qb = rs >= {1'b0, den_q};
    qn = {quo_q[47:0], qb};
    if (ctl_i.start) begin
      num_d = {un, FRAC_BITS'(0)};
      rem_d = '0; den_d = ud; quo_d = '0; big_d = 1'b0;
      neg_d = num_i[47] ^ den_i[47];
      busy_d = 1'b1; cnt_d = CW'(NB);
    end else if (busy_q) begin
      num_d = num_q << 1;
      rem_d = qb ? rs - {1'b0, den_q} : rs;
      if (!big_q) begin
        if (quo_q[48] || qn > lim) big_d = 1'b1;
        else quo_d = qn;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; quo_q <= quo_d;
    big_q <= big_d; neg_q <= neg_d;
  end

  always_comb begin
    logic [48:0] m;
    m = big_q ? lim : quo_q;
    quo_o = neg_q ? 48'(-m) : m[47:0];
  end
  assign sts_o = '{busy: busy_q, done: done_q, ovf: big_q};
endmodule

// ----- sv/mil_mul.sv -----
module mil_mul #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               hi_i,
  input  logic signed [47:0] a_i,
  input  logic signed [47:0] b_i,
  output logic signed [47:0] p_o,
  output logic               ovf_o
);
  // one 24x48 partial product per cycle: low half of a, then high half added in
  logic [47:0] ua, ub;
  logic [23:0] ah;
  logic [71:0] pp;
  logic [71:0] plo_q;
  logic neg_q;
  logic [95:0] full_q;
  logic [95:0] sh;
  logic [48:0] lim;

  assign ua = a_i[47] ? 48'(-a_i) : a_i;
  assign ub = b_i[47] ? 48'(-b_i) : b_i;
  assign ah = hi_i ? ua[47:24] : ua[23:0];
  assign pp = {48'd0, ah} * {24'd0, ub};

  always_ff @(posedge clk_i) begin
    if (hi_i) begin
      full_q <= {24'd0, plo_q} + {pp, 24'd0};
      neg_q <= a_i[47] ^ b_i[47];
    end else begin
      plo_q <= pp;
    end
  end

  always_comb begin
    sh = full_q >> FRAC_BITS;
    lim = neg_q ? 49'h0_8000_0000_0000 : 49'h0_7FFF_FFFF_FFFF;
    ovf_o = (sh > 96'(lim));
    if (ovf_o) p_o = neg_q ? 48'(-lim) : lim[47:0];
    else p_o = neg_q ? 48'(-sh[47:0]) : sh[47:0];
  end
endmodule

// ----- sv/mil_checker.sv -----
`include "matrix_inverse_lu_4x4_top_macros.svh"
module mil_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [1:0]  m_axis_tuser
);
  `MIL_ASSERT(a_no_overlap, clk_i, rst_ni, m_axis_tvalid |-> !s_axis_tready)
  `MIL_ASSERT_HOLD(a_hold, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tdata)
  `MIL_ASSERT(a_last_idx, clk_i, rst_ni, (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[35:32] == 4'hF))
  `MIL_ASSERT(a_status, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tuser != 2'd3))
endmodule

bind matrix_inverse_lu_4x4_top mil_checker u_mil_checker (.*);
